// ===== hw/rtl/hfs_pkg.sv =====
// Shared types, widths and constants of the hop frame scheduler.
// No dependencies; every other file of the block except hfs_ram imports this package.
package hfs_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 40;

  localparam int unsigned TS_W     = 32;
  localparam int unsigned PERIOD_W = 17;
  localparam int unsigned FPH_W    = 8;
  localparam int unsigned CHUSE_W  = 6;
  localparam int unsigned FPS_W    = 7;
  localparam int unsigned NPKT_W   = 2;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned IDX_W    = 6;
  localparam int unsigned CHAN_W   = 7;
  localparam int unsigned SEEN_W   = 4;
  localparam int unsigned RATE_W   = 10;
  localparam int unsigned HOPB_W   = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned POSCMP_W   = 7;

  localparam logic [RATE_W-1:0]   COUNT_MAX       = 10'd1023;
  localparam logic [PERIOD_W-1:0] PERIOD_RST      = 17'd10000;
  localparam logic [FPH_W-1:0]    FPH_RST         = 8'd1;
  localparam logic [CHUSE_W-1:0]  CHUSE_RST       = 6'd40;
  localparam logic [FPS_W-1:0]    FPS_RST         = 7'd100;
  localparam logic [NPKT_W-1:0]   NPKT_RST        = 2'd1;

  typedef enum logic [MODE_W-1:0] {
    MODE_TIME = 2'd0,
    MODE_RX   = 2'd1,
    MODE_PASS = 2'd2,
    MODE_LOAD = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_PERIOD = 3'd0,
    REG_FRAMES_HOP   = 3'd1,
    REG_CHANNELS     = 3'd2,
    REG_FRAMES_SEC   = 3'd3,
    REG_SEND_COUNT   = 3'd4
  } reg_idx_t;

  // Kind of result burst held in the emit stage.
  typedef enum logic [1:0] {
    KIND_NOT_DUE = 2'd0,
    KIND_FRAME   = 2'd1,
    KIND_PASS    = 2'd2
  } kind_t;

  typedef struct packed {
    logic                frame_ready;
    logic [NPKT_W-1:0]   packet_number;
    logic [BYTE_W-1:0]   header_byte;
    logic [CHAN_W-1:0]   send_channel;
    logic                last_item;
    logic [SEEN_W-1:0]   seen_mask;
    logic [RATE_W-1:0]   rate_per_second;
    logic                second_tick;
  } result_t;

endpackage

// ===== hw/rtl/hfs_in_if.sv =====
// Input item channel of the hop frame scheduler.
// Depends on hfs_pkg for field widths.
interface hfs_in_if;
  import hfs_pkg::*;

  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [TS_W-1:0]   timestamp;
  logic [BYTE_W-1:0] first_byte;
  logic [IDX_W-1:0]  entry_index;
  logic [CHAN_W-1:0] entry_channel;

  modport source (output valid, mode, timestamp, first_byte, entry_index, entry_channel,
                  input ready);
  modport sink   (input valid, mode, timestamp, first_byte, entry_index, entry_channel,
                  output ready);
endinterface

// ===== hw/rtl/hfs_out_if.sv =====
// Result channel of the hop frame scheduler.
// Depends on hfs_pkg for field widths.
interface hfs_out_if;
  import hfs_pkg::*;

  logic              valid;
  logic              ready;
  logic              frame_ready;
  logic [NPKT_W-1:0] packet_number;
  logic [BYTE_W-1:0] header_byte;
  logic [CHAN_W-1:0] send_channel;
  logic              last_item;
  logic [SEEN_W-1:0] seen_mask;
  logic [RATE_W-1:0] rate_per_second;
  logic              second_tick;

  modport source (output valid, frame_ready, packet_number, header_byte, send_channel,
                  last_item, seen_mask, rate_per_second, second_tick, input ready);
  modport sink   (input valid, frame_ready, packet_number, header_byte, send_channel,
                  last_item, seen_mask, rate_per_second, second_tick, output ready);
endinterface

// ===== hw/rtl/hfs_cfg_if.sv =====
// Configuration write channel of the hop frame scheduler.
// Depends on hfs_pkg for index and data widths.
interface hfs_cfg_if;
  import hfs_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/hfs_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module hfs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

// ===== hw/rtl/hop_frame_scheduler.sv =====
// Top level of the hop frame scheduler: frame timer, hop stepping, receive
// statistics and channel table. Depends on hfs_pkg, the three channel
// interfaces and hfs_ram.
//
//   Channel   Direction  Transfer carries
//   in_ch     sink       mode, timestamp, first_byte, entry_index, entry_channel
//   out_ch    source     one result: frame/header fields or pass statistics
//   cfg_ch    sink       register index and write data, always ready
//
// An item that yields at most one result is taken every cycle while the
// result port does not stall; its result passes through the emit stage into
// the output register, where it is held. A due frame with N send packets
// hands out N headers, one per cycle while the port does not stall, and the
// next item is taken in the cycle in which the last header moves into the
// output register. The channel table read is registered with the emit stage.
// Reset (rst_n low, synchronous) restores register defaults and clears all
// scheduler state; the channel table is not cleared and must be loaded.
// A stalled result port holds its result and, once the emit stage is full,
// holds in_ch.ready low.
module hop_frame_scheduler #(
  parameter int unsigned TABLE_DEPTH = hfs_pkg::TABLE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  hfs_in_if.sink     in_ch,
  hfs_out_if.source  out_ch,
  hfs_cfg_if.sink    cfg_ch
);
  import hfs_pkg::*;

  localparam int unsigned POS_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [POSCMP_W-1:0] DEPTH_CMP = POSCMP_W'(TABLE_DEPTH);

  // Configuration registers.
  logic [PERIOD_W-1:0] frame_period_r;
  logic [FPH_W-1:0]    frames_per_hop_r;
  logic [CHUSE_W-1:0]  channels_in_use_r;
  logic [FPS_W-1:0]    frames_per_second_r;
  logic [NPKT_W-1:0]   send_count_r;

  // Scheduler state.
  logic [TS_W-1:0]   frame_end_r;
  logic              end_wrapped_r;
  logic [FPH_W-1:0]  hop_count_r;
  logic [POS_W-1:0]  chan_pos_r;
  logic [FPS_W-1:0]  frame_in_sec_r;
  logic [RATE_W-1:0] rx_count_r;
  logic [RATE_W-1:0] last_rate_r;
  logic [SEEN_W-1:0] seen_r;

  // Emit stage: one accepted item whose results are being handed out.
  logic              s1_valid_r;
  kind_t             s1_kind_r;
  logic [NPKT_W-1:0] s1_n_r;
  logic [NPKT_W-1:0] s1_k_r;
  logic [HOPB_W-1:0] s1_hop_r;
  logic [SEEN_W-1:0] s1_seen_r;
  logic [RATE_W-1:0] s1_rate_r;
  logic              s1_tick_r;

  // Output register.
  logic    out_valid_r;
  result_t out_r;
  result_t res_nxt;

  logic [CHAN_W-1:0] ram_rdata;
  logic              ram_we;
  logic              ram_re;

  logic out_free;
  logic s1_last;
  logic s1_emit;
  logic in_ready;
  logic in_fire;
  mode_t in_mode;

  logic [TS_W-1:0] ts_cmp;
  logic [TS_W-1:0] end_cmp;
  logic            due;
  logic [TS_W:0]   end_sum;

  logic [FPH_W-1:0]    hop_inc;
  logic                hop_roll;
  logic [POS_W:0]      pos_inc;
  logic [POSCMP_W-1:0] pos_inc_cmp;
  logic                pos_wrap;
  logic [FPS_W-1:0]    fis_inc;
  logic                sec_close;
  logic                load_ok;

  assign in_mode = mode_t'(in_ch.mode);

  // The emit stage hands one result to the output register whenever that
  // register is empty or being drained in this cycle.
  assign out_free = !out_valid_r || out_ch.ready;
  assign s1_last  = (s1_kind_r != KIND_FRAME) || (s1_n_r == '0) ||
                    ((s1_k_r + NPKT_W'(1)) == s1_n_r);
  assign s1_emit  = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || (s1_emit && s1_last);
  assign in_fire  = in_ch.valid && in_ready;

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;

  // Once the end has wrapped, both sides are moved down by half range,
  // which amounts to flipping their top bits.
  assign ts_cmp  = {in_ch.timestamp[TS_W-1] ^ end_wrapped_r, in_ch.timestamp[TS_W-2:0]};
  assign end_cmp = {frame_end_r[TS_W-1] ^ end_wrapped_r, frame_end_r[TS_W-2:0]};
  assign due     = !(ts_cmp < end_cmp);
  assign end_sum = {1'b0, frame_end_r} + (TS_W+1)'(frame_period_r);

  // Hop counter and table position step; the position wraps at the smaller
  // of the configured channel count and the table depth.
  assign hop_inc     = hop_count_r + FPH_W'(1);
  assign hop_roll    = hop_inc >= frames_per_hop_r;
  assign pos_inc     = {1'b0, chan_pos_r} + (POS_W+1)'(1);
  assign pos_inc_cmp = POSCMP_W'(pos_inc);
  assign pos_wrap    = (pos_inc_cmp >= POSCMP_W'(channels_in_use_r)) ||
                       (pos_inc_cmp >= DEPTH_CMP);

  assign fis_inc   = frame_in_sec_r + FPS_W'(1);
  assign sec_close = fis_inc >= frames_per_second_r;

  assign load_ok = POSCMP_W'(in_ch.entry_index) < DEPTH_CMP;
  assign ram_we  = in_fire && (in_mode == MODE_LOAD) && load_ok;
  assign ram_re  = in_fire && (in_mode == MODE_TIME) && due;

  // The table read for a due frame is issued at the transfer; its data is
  // held by the RAM until the next due frame, which cannot be taken before
  // the current burst has emitted its last header.
  hfs_ram #(
    .WIDTH (CHAN_W),
    .DEPTH (TABLE_DEPTH),
    .AW    (POS_W)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_ch.entry_index[POS_W-1:0]),
    .wdata (in_ch.entry_channel),
    .re    (ram_re),
    .raddr (chan_pos_r),
    .rdata (ram_rdata)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_period_r      <= PERIOD_RST;
      frames_per_hop_r    <= FPH_RST;
      channels_in_use_r   <= CHUSE_RST;
      frames_per_second_r <= FPS_RST;
      send_count_r        <= NPKT_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_FRAME_PERIOD: frame_period_r      <= cfg_ch.data[PERIOD_W-1:0];
        REG_FRAMES_HOP:   frames_per_hop_r    <= cfg_ch.data[FPH_W-1:0];
        REG_CHANNELS:     channels_in_use_r   <= cfg_ch.data[CHUSE_W-1:0];
        REG_FRAMES_SEC:   frames_per_second_r <= cfg_ch.data[FPS_W-1:0];
        REG_SEND_COUNT:   send_count_r        <= cfg_ch.data[NPKT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Scheduler state, updated at the transfer of each item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_end_r    <= '0;
      end_wrapped_r  <= 1'b0;
      hop_count_r    <= '0;
      chan_pos_r     <= '0;
      frame_in_sec_r <= '0;
      rx_count_r     <= '0;
      last_rate_r    <= '0;
      seen_r         <= '0;
    end else if (in_fire) begin
      case (in_mode)
        MODE_TIME: begin
          if (due) begin
            frame_end_r   <= end_sum[TS_W-1:0];
            end_wrapped_r <= end_sum[TS_W];
            if (hop_roll) begin
              hop_count_r <= '0;
              chan_pos_r  <= pos_wrap ? '0 : pos_inc[POS_W-1:0];
            end else begin
              hop_count_r <= hop_inc;
            end
          end
        end
        MODE_RX: begin
          seen_r <= seen_r | (SEEN_W'(1) << in_ch.first_byte[1:0]);
          if (rx_count_r != COUNT_MAX) begin
            rx_count_r <= rx_count_r + RATE_W'(1);
          end
        end
        MODE_PASS: begin
          seen_r <= '0;
          if (sec_close) begin
            frame_in_sec_r <= '0;
            last_rate_r    <= rx_count_r;
            rx_count_r     <= '0;
          end else begin
            frame_in_sec_r <= fis_inc;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Emit stage control. A new item only enters when the stage is empty or
  // is handing out its last result in the same cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_k_r     <= '0;
    end else begin
      if (in_fire && (in_mode == MODE_TIME || in_mode == MODE_PASS)) begin
        s1_valid_r <= 1'b1;
        s1_k_r     <= '0;
      end else if (s1_emit) begin
        if (s1_last) begin
          s1_valid_r <= 1'b0;
        end else begin
          s1_k_r <= s1_k_r + NPKT_W'(1);
        end
      end
    end
  end

  // Emit stage payload, captured with the state as it stands before the update.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_kind_r <= (in_mode == MODE_PASS) ? KIND_PASS : (due ? KIND_FRAME : KIND_NOT_DUE);
      s1_n_r    <= send_count_r;
      s1_hop_r  <= hop_count_r[HOPB_W-1:0];
      s1_seen_r <= seen_r;
      s1_rate_r <= sec_close ? rx_count_r : last_rate_r;
      s1_tick_r <= sec_close;
    end
  end

  // Result of the current emit step.
  always_comb begin
    res_nxt = '0;
    case (s1_kind_r)
      KIND_NOT_DUE: begin
        res_nxt.last_item = 1'b1;
      end
      KIND_FRAME: begin
        res_nxt.frame_ready  = 1'b1;
        res_nxt.send_channel = ram_rdata;
        res_nxt.last_item    = s1_last;
        // With zero send packets a single result goes out without a header.
        if (s1_n_r != '0) begin
          res_nxt.packet_number = s1_k_r;
          res_nxt.header_byte   = {s1_hop_r, 3'b000, s1_k_r};
        end
      end
      KIND_PASS: begin
        res_nxt.last_item       = 1'b1;
        res_nxt.seen_mask       = s1_seen_r;
        res_nxt.rate_per_second = s1_rate_r;
        res_nxt.second_tick     = s1_tick_r;
      end
      default: begin
        res_nxt.last_item = 1'b1;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_emit) begin
      out_r <= res_nxt;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.frame_ready     = out_r.frame_ready;
  assign out_ch.packet_number   = out_r.packet_number;
  assign out_ch.header_byte     = out_r.header_byte;
  assign out_ch.send_channel    = out_r.send_channel;
  assign out_ch.last_item       = out_r.last_item;
  assign out_ch.seen_mask       = out_r.seen_mask;
  assign out_ch.rate_per_second = out_r.rate_per_second;
  assign out_ch.second_tick     = out_r.second_tick;

endmodule

// ===== hw/rtl/hfs_checker.sv =====
// Port-level checks of the hop frame scheduler, bound to the top level.
// Depends on hfs_pkg and on the port names of hop_frame_scheduler.
module hfs_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        frame_ready,
  input logic [hfs_pkg::NPKT_W-1:0]  packet_number,
  input logic [hfs_pkg::BYTE_W-1:0]  header_byte,
  input logic [hfs_pkg::CHAN_W-1:0]  send_channel,
  input logic                        last_item
);
  import hfs_pkg::*;

  // No result is offered in the cycle after a reset cycle.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // A stalled result keeps its payload.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(header_byte) &&
      $stable(send_channel) && $stable(last_item))
    else $error("stalled result changed");

  // Headers of one frame follow back to back on the same channel.
  a_burst_next: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !last_item |=> out_valid && frame_ready &&
      packet_number == $past(packet_number) + NPKT_W'(1) &&
      send_channel == $past(send_channel))
    else $error("header burst broken");

  // Only frame headers come in groups, and each carries its packet index.
  a_header_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !last_item |-> frame_ready && header_byte[1:0] == packet_number)
    else $error("non-final result is not a frame header");

endmodule

bind hop_frame_scheduler hfs_checker u_hfs_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .frame_ready   (out_ch.frame_ready),
  .packet_number (out_ch.packet_number),
  .header_byte   (out_ch.header_byte),
  .send_channel  (out_ch.send_channel),
  .last_item     (out_ch.last_item)
);

// ===== test/tb_hop_frame_scheduler.sv =====
// Self-checking testbench for hop_frame_scheduler: directed and random items and register
// settings, with every result transfer compared against a cycle-free predictor kept here.
// Depends on hfs_pkg, the hfs_in_if, hfs_out_if and hfs_cfg_if interfaces and the RTL.
module tb_hop_frame_scheduler;
  timeunit 1ns;
  timeprecision 1ps;

  import hfs_pkg::*;

  localparam int unsigned TABLE_DEPTH      = TABLE_DEPTH_DEF;
  localparam int unsigned CLK_PERIOD       = 10;
  localparam int unsigned RESET_CYCLES     = 10;
  // Pause after draining that covers the table read and items with no result.
  localparam int unsigned SETTLE_CYCLES    = 4;
  localparam int unsigned REPORT_LIMIT     = 10;
  localparam int unsigned TIMEOUT_NS       = 10_000_000;
  localparam int unsigned REG_FIRST_UNUSED = int'(REG_SEND_COUNT) + 1;
  localparam int unsigned PERIOD_MAX       = (1 << PERIOD_W) - 1;
  localparam int unsigned IDX_MAX          = (1 << IDX_W) - 1;
  localparam logic [TS_W-1:0] HALF_RANGE   = 32'h8000_0000;
  localparam logic [TS_W-1:0] TS_MAX       = 32'hFFFF_FFFF;

  typedef struct {
    mode_t             mode;
    logic [TS_W-1:0]   timestamp;
    logic [BYTE_W-1:0] first_byte;
    logic [IDX_W-1:0]  entry_index;
    logic [CHAN_W-1:0] entry_channel;
  } sched_item_t;

  typedef struct {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } reg_write_t;

  logic clk = 1'b0;
  logic rst_n;

  hfs_in_if  in_ch ();
  hfs_out_if out_ch ();
  hfs_cfg_if cfg_ch ();

  hop_frame_scheduler #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Shadow copy of the register file, starting from the reset values.
  logic [PERIOD_W-1:0] cfg_period      = PERIOD_RST;
  logic [FPH_W-1:0]    cfg_frames_hop  = FPH_RST;
  logic [CHUSE_W-1:0]  cfg_channels    = CHUSE_RST;
  logic [FPS_W-1:0]    cfg_frames_sec  = FPS_RST;
  logic [NPKT_W-1:0]   cfg_send_count  = NPKT_RST;

  // Shadow copy of the scheduler state.
  logic [TS_W-1:0]     sched_frame_end    = '0;
  logic                sched_end_wrapped  = 1'b0;
  logic [FPH_W-1:0]    sched_hop          = '0;
  logic [IDX_W-1:0]    sched_position     = '0;
  logic [FPS_W-1:0]    sched_frame_in_sec = '0;
  logic [RATE_W-1:0]   sched_rx_count     = '0;
  logic [RATE_W-1:0]   sched_last_rate    = '0;
  logic [SEEN_W-1:0]   sched_seen         = '0;
  logic [CHAN_W-1:0]   chan_table [TABLE_DEPTH];

  sched_item_t pending_items [$];
  result_t     expected_results [$];
  reg_write_t  reg_writes [$];
  sched_item_t driven_item;
  result_t     got_result;
  result_t     want_result;

  int unsigned send_idle_pct = 28;
  int unsigned recv_idle_pct = 55;
  int          items_outstanding = 0;
  int unsigned items_accepted = 0;
  int unsigned results_checked = 0;
  int unsigned due_frames = 0;
  int unsigned end_wraps = 0;
  int unsigned windows_closed = 0;
  int unsigned register_writes = 0;
  int unsigned error_count = 0;

  // Works out the results that one accepted item causes and updates the shadow state.
  function automatic void predict_results(sched_item_t it);
    logic [TS_W-1:0]   ts_cmp;
    logic [TS_W-1:0]   end_cmp;
    logic [TS_W-1:0]   end_next;
    logic [CHAN_W-1:0] chan;
    int unsigned       limit;
    result_t           r;
    r = '0;
    case (it.mode)
      MODE_TIME: begin
        ts_cmp  = it.timestamp;
        end_cmp = sched_frame_end;
        // Once the end has wrapped, both sides are compared half a range lower.
        if (sched_end_wrapped) begin
          ts_cmp  = ts_cmp - HALF_RANGE;
          end_cmp = end_cmp - HALF_RANGE;
        end
        if (ts_cmp < end_cmp) begin
          r.last_item = 1'b1;
          expected_results.push_back(r);
        end else begin
          due_frames++;
          end_next          = sched_frame_end + TS_W'(cfg_period);
          sched_end_wrapped = (end_next < sched_frame_end);
          if (sched_end_wrapped) end_wraps++;
          sched_frame_end   = end_next;
          chan              = chan_table[sched_position];
          r.frame_ready     = 1'b1;
          r.send_channel    = chan;
          if (cfg_send_count == '0) begin
            r.last_item = 1'b1;
            expected_results.push_back(r);
          end else begin
            for (int k = 0; k < int'(cfg_send_count); k++) begin
              r.packet_number = NPKT_W'(k);
              r.header_byte   = {sched_hop[HOPB_W-1:0], 3'b000, NPKT_W'(k)};
              r.last_item     = (k + 1 == int'(cfg_send_count));
              expected_results.push_back(r);
            end
          end
          // Hop stepping: the position wraps at the smaller of the channel count and
          // the table depth.
          limit     = (cfg_channels > TABLE_DEPTH) ? TABLE_DEPTH : cfg_channels;
          sched_hop = sched_hop + 1'b1;
          if (sched_hop >= cfg_frames_hop) begin
            sched_hop      = '0;
            sched_position = sched_position + 1'b1;
            if (sched_position >= limit) sched_position = '0;
          end
        end
      end
      MODE_RX: begin
        sched_seen = sched_seen | (SEEN_W'(1) << it.first_byte[1:0]);
        if (sched_rx_count < COUNT_MAX) sched_rx_count = sched_rx_count + 1'b1;
      end
      MODE_PASS: begin
        sched_frame_in_sec = sched_frame_in_sec + 1'b1;
        if (sched_frame_in_sec >= cfg_frames_sec) begin
          sched_frame_in_sec = '0;
          sched_last_rate    = sched_rx_count;
          sched_rx_count     = '0;
          r.second_tick      = 1'b1;
          windows_closed++;
        end
        r.last_item       = 1'b1;
        r.seen_mask       = sched_seen;
        r.rate_per_second = sched_last_rate;
        expected_results.push_back(r);
        sched_seen = '0;
      end
      MODE_LOAD: begin
        if (it.entry_index < TABLE_DEPTH) chan_table[it.entry_index] = it.entry_channel;
      end
      default: ;
    endcase
  endfunction

  function automatic string describe(result_t r);
    return $sformatf("ready=%0b pkt=%0d hdr=%02h chan=%0d last=%0b seen=%04b rate=%0d tick=%0b",
                     r.frame_ready, r.packet_number, r.header_byte, r.send_channel,
                     r.last_item, r.seen_mask, r.rate_per_second, r.second_tick);
  endfunction

  // Fields that the mode does not use still carry random values.
  function automatic sched_item_t noise_item(mode_t m);
    sched_item_t it;
    it.mode          = m;
    it.timestamp     = $urandom();
    it.first_byte    = BYTE_W'($urandom());
    it.entry_index   = IDX_W'($urandom());
    it.entry_channel = CHAN_W'($urandom());
    return it;
  endfunction

  function automatic void queue_item(sched_item_t it);
    pending_items.push_back(it);
    items_outstanding++;
  endfunction

  function automatic void push_time(logic [TS_W-1:0] ts);
    sched_item_t it;
    it           = noise_item(MODE_TIME);
    it.timestamp = ts;
    queue_item(it);
  endfunction

  function automatic void push_rx(logic [BYTE_W-1:0] first_byte);
    sched_item_t it;
    it            = noise_item(MODE_RX);
    it.first_byte = first_byte;
    queue_item(it);
  endfunction

  function automatic void push_pass();
    queue_item(noise_item(MODE_PASS));
  endfunction

  function automatic void push_load(logic [IDX_W-1:0] index, logic [CHAN_W-1:0] chan);
    sched_item_t it;
    it               = noise_item(MODE_LOAD);
    it.entry_index   = index;
    it.entry_channel = chan;
    queue_item(it);
  endfunction

  // The register value sits in the low bits; the bits above the register width are random
  // and must be dropped by the block.
  function automatic void queue_register(logic [CFG_IDX_W-1:0] index, logic [31:0] value);
    reg_write_t w;
    w.index = index;
    w.data  = CFG_DATA_W'($urandom());
    case (index)
      REG_FRAME_PERIOD: w.data                 = value[PERIOD_W-1:0];
      REG_FRAMES_HOP:   w.data[FPH_W-1:0]      = value[FPH_W-1:0];
      REG_CHANNELS:     w.data[CHUSE_W-1:0]    = value[CHUSE_W-1:0];
      REG_FRAMES_SEC:   w.data[FPS_W-1:0]      = value[FPS_W-1:0];
      REG_SEND_COUNT:   w.data[NPKT_W-1:0]     = value[NPKT_W-1:0];
      default: ;
    endcase
    reg_writes.push_back(w);
  endfunction

  // Mostly a typical value, now and then one of the two extremes.
  function automatic int unsigned pick_setting(int unsigned lo, int unsigned hi,
                                               int unsigned typ_lo, int unsigned typ_hi);
    case ($urandom_range(0, 7))
      0:       return lo;
      1:       return hi;
      default: return $urandom_range(typ_lo, typ_hi);
    endcase
  endfunction

  function automatic void randomize_settings();
    queue_register(REG_FRAME_PERIOD, pick_setting(0, PERIOD_MAX, 1, 100000));
    queue_register(REG_FRAMES_HOP, pick_setting(0, (1 << FPH_W) - 1, 1, 9));
    queue_register(REG_CHANNELS, pick_setting(0, (1 << CHUSE_W) - 1, 1, TABLE_DEPTH));
    queue_register(REG_FRAMES_SEC, pick_setting(0, (1 << FPS_W) - 1, 1, 12));
    queue_register(REG_SEND_COUNT, $urandom_range(0, (1 << NPKT_W) - 1));
  endfunction

  // Sends the queued register writes back to back. Valid stays high across the batch
  // and drops in the step of the last transfer.
  task automatic flush_register_writes();
    reg_write_t w;
    while (reg_writes.size() != 0) begin
      w = reg_writes.pop_front();
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= w.index;
      cfg_ch.data  <= w.data;
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
      register_writes++;
      case (w.index)
        REG_FRAME_PERIOD: cfg_period     = w.data[PERIOD_W-1:0];
        REG_FRAMES_HOP:   cfg_frames_hop = w.data[FPH_W-1:0];
        REG_CHANNELS:     cfg_channels   = w.data[CHUSE_W-1:0];
        REG_FRAMES_SEC:   cfg_frames_sec = w.data[FPS_W-1:0];
        REG_SEND_COUNT:   cfg_send_count = w.data[NPKT_W-1:0];
        default: ;
      endcase
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // The block is idle once every item has been taken and every expected result has come.
  // Items with no result get a short pause on top before registers may change.
  task automatic wait_until_drained();
    while (items_outstanding != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Time samples follow a notional microsecond clock that starts just before the stored
  // frame end and advances by up to one and a half periods, so due and not-due samples
  // mix. One sample in ten is a random timestamp instead.
  task automatic run_random_phase(input int unsigned n_items);
    logic [TS_W-1:0] now_us;
    int unsigned     step_max;
    int unsigned     roll;
    now_us   = sched_frame_end - TS_W'($urandom_range(0, int'(cfg_period)));
    step_max = int'(cfg_period) + int'(cfg_period) / 2;
    repeat (n_items) begin
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
        if ($urandom_range(0, 9) == 0) begin
          push_time($urandom());
        end else begin
          now_us = now_us + TS_W'($urandom_range(0, step_max));
          push_time(now_us);
        end
      end else if (roll < 72) begin
        push_rx(BYTE_W'($urandom()));
      end else if (roll < 88) begin
        push_pass();
      end else begin
        push_load(IDX_W'($urandom_range(0, IDX_MAX)), CHAN_W'($urandom()));
      end
    end
  endtask

  // Driver: an item stays on the channel until its transfer; the predictor runs in the
  // step of the transfer. The sender idles at random between items.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        predict_results(driven_item);
        items_accepted++;
        items_outstanding--;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          driven_item            = pending_items.pop_front();
          in_ch.valid         <= 1'b1;
          in_ch.mode          <= driven_item.mode;
          in_ch.timestamp     <= driven_item.timestamp;
          in_ch.first_byte    <= driven_item.first_byte;
          in_ch.entry_index   <= driven_item.entry_index;
          in_ch.entry_channel <= driven_item.entry_channel;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: every result transfer is compared field by field with the oldest
  // expectation. The receiver stalls at random.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got_result.frame_ready     = out_ch.frame_ready;
        got_result.packet_number   = out_ch.packet_number;
        got_result.header_byte     = out_ch.header_byte;
        got_result.send_channel    = out_ch.send_channel;
        got_result.last_item       = out_ch.last_item;
        got_result.seen_mask       = out_ch.seen_mask;
        got_result.rate_per_second = out_ch.rate_per_second;
        got_result.second_tick     = out_ch.second_tick;
        if (expected_results.size() == 0) begin
          error_count++;
          if (error_count <= REPORT_LIMIT)
            $display("%0t: result with nothing expected: %s", $time, describe(got_result));
        end else begin
          want_result = expected_results.pop_front();
          results_checked++;
          if (got_result.frame_ready     !== want_result.frame_ready   ||
              got_result.packet_number   !== want_result.packet_number ||
              got_result.header_byte     !== want_result.header_byte   ||
              got_result.send_channel    !== want_result.send_channel  ||
              got_result.last_item       !== want_result.last_item     ||
              got_result.seen_mask       !== want_result.seen_mask     ||
              got_result.rate_per_second !== want_result.rate_per_second ||
              got_result.second_tick     !== want_result.second_tick) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
              $display("%0t: result %0d differs\n  expected %s\n  actual   %s", $time,
                       results_checked, describe(want_result), describe(got_result));
          end
        end
      end
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  initial begin
    // Every input of the block is known from time zero.
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.mode          = MODE_TIME;
    in_ch.timestamp     = '0;
    in_ch.first_byte    = '0;
    in_ch.entry_index   = '0;
    in_ch.entry_channel = '0;
    out_ch.ready        = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = '0;
    cfg_ch.data         = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // The channel table has no reset value, so every entry is loaded before the first
    // due frame can read it. The two extreme channel numbers go into the first entries.
    for (int e = 0; e < TABLE_DEPTH; e++) begin
      push_load(IDX_W'(e), (e == 0) ? {CHAN_W{1'b1}} :
                           (e == 1) ? {CHAN_W{1'b0}} : CHAN_W'($urandom()));
    end

    // Directed items with the reset settings. The first sample is due because the frame
    // end starts at zero; then a sample inside the frame, one just short of the end and
    // one exactly at it.
    push_time('0);
    push_time('0);
    push_time(32'd9999);
    push_time(32'd10000);
    push_rx(8'hFF);
    push_rx(8'h00);
    push_rx(8'h5A);
    push_pass();
    push_pass();
    // Loads beyond the table depth are ignored.
    push_load(IDX_W'(TABLE_DEPTH), {CHAN_W{1'b1}});
    push_load(IDX_W'(IDX_MAX), {CHAN_W{1'b0}});
    push_time(TS_MAX);
    wait_until_drained();

    // One-microsecond frames with three packets, a hop on every frame, a channel count
    // above the table depth and a window that closes on every pass. The unused register
    // indexes are written too and must change nothing.
    queue_register(REG_FRAME_PERIOD, 1);
    queue_register(REG_SEND_COUNT, 3);
    queue_register(REG_FRAMES_HOP, 0);
    queue_register(REG_CHANNELS, (1 << CHUSE_W) - 1);
    queue_register(REG_FRAMES_SEC, 0);
    for (int i = REG_FIRST_UNUSED; i < (1 << CFG_IDX_W); i++)
      queue_register(CFG_IDX_W'(i), $urandom());
    flush_register_writes();
    push_time(TS_MAX);
    push_time(TS_MAX);
    push_rx(8'h02);
    push_pass();
    push_pass();
    wait_until_drained();

    // Longest period the field holds, zero packets per frame, no channels and the
    // slowest hop and window settings.
    queue_register(REG_FRAME_PERIOD, PERIOD_MAX);
    queue_register(REG_SEND_COUNT, 0);
    queue_register(REG_CHANNELS, 0);
    queue_register(REG_FRAMES_HOP, (1 << FPH_W) - 1);
    queue_register(REG_FRAMES_SEC, (1 << FPS_W) - 1);
    flush_register_writes();
    push_time(TS_MAX);
    push_time(TS_MAX);
    push_time('0);
    push_pass();

    // Random part, first stage: the sender idles less often than the receiver.
    repeat (2) begin
      wait_until_drained();
      randomize_settings();
      flush_register_writes();
      run_random_phase(60);
    end

    // Second stage: the idling rates are swapped.
    wait_until_drained();
    send_idle_pct = 55;
    recv_idle_pct = 28;
    repeat (2) begin
      wait_until_drained();
      randomize_settings();
      flush_register_writes();
      run_random_phase(60);
    end

    // Third stage: neither side idles, so items and results follow back to back.
    wait_until_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (2) begin
      wait_until_drained();
      randomize_settings();
      flush_register_writes();
      run_random_phase(55);
    end

    wait_until_drained();
    $display("run covered %0d items, %0d results checked, %0d register writes",
             items_accepted, results_checked, register_writes);
    $display("due frames %0d, frame end wraps %0d, one-second windows closed %0d",
             due_frames, end_wraps, windows_closed);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Guard against a hang: far longer than the slowest correct run.
  initial begin
    #TIMEOUT_NS;
    $display("timeout with %0d items and %0d results outstanding",
             items_outstanding, expected_results.size());
    $display("status: fail");
    $finish;
  end

endmodule
